@@ hw/rtl/pfr_pkg.sv @@
// Shared types, codes and constants of the particle filter resampler.
`default_nettype none
package pfr_pkg;

   localparam int SU_W = 64;

   localparam logic [1:0] OP_PLACE = 2'd0;
   localparam logic [1:0] OP_MATCH = 2'd1;
   localparam logic [1:0] OP_MOVE  = 2'd2;
   localparam logic [1:0] OP_DRAW  = 2'd3;

   localparam logic [1:0] ST_DETECTED = 2'd0;
   localparam logic [1:0] ST_CAUTION  = 2'd1;
   localparam logic [1:0] ST_LOST     = 2'd2;

   localparam logic CSR_PARTICLES_IN_USE = 1'b0;
   localparam logic CSR_MAX_SPREAD       = 1'b1;

   localparam logic [1:0] SU_MUL  = 2'd0;
   localparam logic [1:0] SU_DIV  = 2'd1;
   localparam logic [1:0] SU_SQRT = 2'd2;

   localparam logic [SU_W-1:0] WEIGHT_NUM = 64'd4096000;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         index;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        draw_fraction;
   } req_type;

   typedef struct packed {
      logic signed [15:0] mean_x;
      logic signed [15:0] mean_y;
      logic [15:0]        spread;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic            start;
      logic [1:0]      op;
      logic [SU_W-1:0] a;
      logic [SU_W-1:0] b;
   } su_cmd_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [SU_W-1:0] q;
      logic [SU_W-1:0] r;
   } su_res_type;

endpackage
`default_nettype wire

@@ hw/rtl/particle_filter_resampler_top.sv @@
// Top level of the particle filter resampler: sequencer, memories and ports.
`default_nettype none
// One beat is taken at a time; req_ready is high only between beats. A place
// writes its slot after any wrap of the slot index; a match point is stored
// as it is taken. A move walks the stored match points for the nearest one,
// then uses the shared serial unit for a square root and a divide. A draw
// multiplies the total weight by the draw fraction, then binary searches the
// running weights; the last draw of a frame adds, per axis, a divide for the
// mean, two serial multiplies, a root and a divide. The result beat waits in
// an output register while new beats are taken. Particle, weight and match
// memories hold garbage until written and need no clearing pass after reset.
module particle_filter_resampler_top
   import pfr_pkg::*;
#(
   parameter int PARTICLE_SLOTS = 256,
   parameter int MATCH_SLOTS    = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int PIDX = $clog2(PARTICLE_SLOTS);
   localparam int CW   = $clog2(PARTICLE_SLOTS + 1);
   localparam int MCW  = $clog2(MATCH_SLOTS + 1);
   localparam int MAW  = (MATCH_SLOTS > 1) ? $clog2(MATCH_SLOTS) : 1;
   localparam int SW   = 16 + CW;
   localparam int QW   = 32 + CW;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_PLACE    = 5'd1;
   localparam logic [4:0] S_MV_RD    = 5'd2;
   localparam logic [4:0] S_MV_UPD   = 5'd3;
   localparam logic [4:0] S_MV_MR    = 5'd4;
   localparam logic [4:0] S_MV_EX    = 5'd5;
   localparam logic [4:0] S_MV_SQX   = 5'd6;
   localparam logic [4:0] S_MV_SQY   = 5'd7;
   localparam logic [4:0] S_MV_CMP   = 5'd8;
   localparam logic [4:0] S_MV_SQRT  = 5'd9;
   localparam logic [4:0] S_MV_DIV   = 5'd10;
   localparam logic [4:0] S_MV_ACC   = 5'd11;
   localparam logic [4:0] S_MV_CWADD = 5'd12;
   localparam logic [4:0] S_DR_TOT   = 5'd13;
   localparam logic [4:0] S_DR_MS    = 5'd14;
   localparam logic [4:0] S_DR_MUL   = 5'd15;
   localparam logic [4:0] S_DR_BS    = 5'd16;
   localparam logic [4:0] S_DR_BSC   = 5'd17;
   localparam logic [4:0] S_DR_RD    = 5'd18;
   localparam logic [4:0] S_DR_CP    = 5'd19;
   localparam logic [4:0] S_DR_SQX   = 5'd20;
   localparam logic [4:0] S_DR_SQY   = 5'd21;
   localparam logic [4:0] S_F_MS     = 5'd22;
   localparam logic [4:0] S_F_MEAN   = 5'd23;
   localparam logic [4:0] S_F_NSQ    = 5'd24;
   localparam logic [4:0] S_F_SS     = 5'd25;
   localparam logic [4:0] S_F_SQRT   = 5'd26;
   localparam logic [4:0] S_F_SD     = 5'd27;
   localparam logic [4:0] S_F_OUT    = 5'd28;

   logic [4:0]           state_ff, state_in;
   req_type              req_ff, req_in;
   logic [8:0]           pu_ff, pu_in;
   logic [15:0]          ms_ff, ms_in;
   logic                 bsel_ff, bsel_in;
   logic [MCW-1:0]       mc_ff, mc_in;
   logic [MCW-1:0]       k_ff, k_in;
   logic [CW-1:0]        mv_ff, mv_in;
   logic [CW-1:0]        dc_ff, dc_in;
   logic signed [15:0]   px_ff, px_in;
   logic signed [15:0]   py_ff, py_in;
   logic signed [16:0]   ex_ff, ex_in;
   logic signed [16:0]   ey_ff, ey_in;
   logic [33:0]          sqa_ff, sqa_in;
   logic [33:0]          sqb_ff, sqb_in;
   logic [34:0]          best_ff, best_in;
   logic [31:0]          w_ff, w_in;
   logic [31:0]          target_ff, target_in;
   logic [PIDX-1:0]      lo_ff, lo_in;
   logic [PIDX-1:0]      hi_ff, hi_in;
   logic [PIDX-1:0]      mid_ff, mid_in;
   logic [PIDX-1:0]      sel_ff, sel_in;
   logic signed [SW-1:0] sum_x_ff, sum_x_in;
   logic signed [SW-1:0] sum_y_ff, sum_y_in;
   logic [QW-1:0]        sqs_x_ff, sqs_x_in;
   logic [QW-1:0]        sqs_y_ff, sqs_y_in;
   logic                 axis_ff, axis_in;
   logic [SU_W-1:0]      t1_ff, t1_in;
   logic [15:0]          mean_x_ff, mean_x_in;
   logic [15:0]          mean_y_ff, mean_y_in;
   logic [29:0]          sd_x_ff, sd_x_in;
   logic [29:0]          sd_y_ff, sd_y_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [31:0] bank_ff [2*PARTICLE_SLOTS];
   logic [31:0] cw_ff [PARTICLE_SLOTS];
   logic [31:0] match_ff [MATCH_SLOTS];
   logic [31:0] bank_rd_ff, cw_rd_ff, match_rd_ff;

   logic            bank_we, cw_we, m_we;
   logic [PIDX:0]   bank_addr;
   logic [PIDX-1:0] cw_addr;
   logic [MAW-1:0]  m_addr;
   logic [31:0]     bank_wd, cw_wd, m_wd;

   logic [CW-1:0]        n_cur;
   logic signed [16:0]   sq_in;
   logic signed [33:0]   sq_mul;
   logic [33:0]          sq_prod;
   su_cmd_type           su_cmd;
   su_res_type           su_res;
   logic                 accept;
   logic [34:0]          dist_q;
   logic [34:0]          dist_min;
   logic [32:0]          acc_sum;
   logic [PIDX:0]        mid_sum;
   logic signed [SW-1:0] s_sel;
   logic [SW-1:0]        s_abs;
   logic [QW-1:0]        sq_sel;
   logic [15:0]          mean_v;
   logic [30:0]          sd_sum;
   logic [29:0]          sd_half;
   logic [15:0]          spread_v;
   logic [1:0]           status_v;
   logic [CW-1:0]        dc_next;

   pfr_serial_unit u_serial (
      .clock (clock),
      .reset (reset),
      .cmd   (su_cmd),
      .res   (su_res)
   );

   assign sq_mul  = sq_in * sq_in;
   assign sq_prod = unsigned'(sq_mul);
   assign accept  = req_valid && req_ready;

   always_comb begin
      if (pu_ff == 9'd0) begin
         n_cur = CW'(1);
      end else if (32'(pu_ff) > PARTICLE_SLOTS) begin
         n_cur = CW'(PARTICLE_SLOTS);
      end else begin
         n_cur = CW'(pu_ff);
      end
   end

   always_comb begin
      s_sel    = axis_ff ? sum_y_ff : sum_x_ff;
      sq_sel   = axis_ff ? sqs_y_ff : sqs_x_ff;
      s_abs    = s_sel[SW-1] ? unsigned'(-s_sel) : unsigned'(s_sel);
      sd_sum   = {1'b0, sd_x_ff} + {1'b0, sd_y_ff};
      sd_half  = sd_sum[30:1];
      spread_v = (sd_half > 30'd65535) ? 16'hFFFF : sd_half[15:0];
      if ({1'b0, spread_v, 1'b0} < 18'({2'b00, ms_ff} * 18'd3)) begin
         status_v = ST_DETECTED;
      end else if ({1'b0, spread_v} < {ms_ff, 1'b0}) begin
         status_v = ST_CAUTION;
      end else begin
         status_v = ST_LOST;
      end
      if (s_sel[SW-1]) begin
         mean_v = (su_res.r != '0) ? ~su_res.q[15:0] : 16'(~su_res.q[15:0] + 16'd1);
      end else begin
         mean_v = su_res.q[15:0];
      end
      dist_q   = {1'b0, sqa_ff} + {1'b0, sqb_ff};
      dist_min = (dist_q < best_ff) ? dist_q : best_ff;
      acc_sum  = {1'b0, w_ff} + {1'b0, cw_rd_ff};
      mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
      dc_next  = dc_ff + CW'(1);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      pu_in        = pu_ff;
      ms_in        = ms_ff;
      bsel_in      = bsel_ff;
      mc_in        = mc_ff;
      k_in         = k_ff;
      mv_in        = mv_ff;
      dc_in        = dc_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      sqa_in       = sqa_ff;
      sqb_in       = sqb_ff;
      best_in      = best_ff;
      w_in         = w_ff;
      target_in    = target_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      sel_in       = sel_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      sqs_x_in     = sqs_x_ff;
      sqs_y_in     = sqs_y_ff;
      axis_in      = axis_ff;
      t1_in        = t1_ff;
      mean_x_in    = mean_x_ff;
      mean_y_in    = mean_y_ff;
      sd_x_in      = sd_x_ff;
      sd_y_in      = sd_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      bank_we      = 1'b0;
      bank_addr    = {bsel_ff, mv_ff[PIDX-1:0]};
      bank_wd      = {py_ff, px_ff};
      cw_we        = 1'b0;
      cw_addr      = mv_ff[PIDX-1:0];
      cw_wd        = w_ff;
      m_we         = 1'b0;
      m_addr       = MAW'(k_ff);
      m_wd         = {req_data.y, req_data.x};
      sq_in        = ex_ff;
      su_cmd       = '0;
      req_ready    = (state_ff == S_IDLE);

      if (csr_we) begin
         case (csr_index)
            CSR_PARTICLES_IN_USE: pu_in = csr_wdata[8:0];
            CSR_MAX_SPREAD:       ms_in = csr_wdata;
            default:              ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               case (req_data.op)
                  OP_PLACE: state_in = S_PLACE;
                  OP_MATCH: begin
                     if (32'(mc_ff) < MATCH_SLOTS) begin
                        m_we   = 1'b1;
                        m_addr = MAW'(mc_ff);
                        mc_in  = MCW'(mc_ff + 1'b1);
                     end
                  end
                  OP_MOVE:  state_in = S_MV_RD;
                  default:  state_in = S_DR_TOT;
               endcase
            end
         end
         S_PLACE: begin
            if (32'(req_ff.index) >= PARTICLE_SLOTS) begin
               req_in.index = req_ff.index - 8'(PARTICLE_SLOTS);
            end else begin
               bank_we   = 1'b1;
               bank_addr = {bsel_ff, PIDX'(req_ff.index)};
               bank_wd   = {req_ff.y, req_ff.x};
               state_in  = S_IDLE;
            end
         end
         S_MV_RD: begin
            state_in = (mv_ff >= n_cur) ? S_IDLE : S_MV_UPD;
         end
         S_MV_UPD: begin
            px_in     = signed'(bank_rd_ff[15:0]) + req_ff.x;
            py_in     = signed'(bank_rd_ff[31:16]) + req_ff.y;
            bank_we   = 1'b1;
            bank_wd   = {py_in, px_in};
            k_in      = '0;
            best_in   = '1;
            if (mc_ff == '0) begin
               w_in     = '0;
               state_in = S_MV_ACC;
            end else begin
               state_in = S_MV_MR;
            end
         end
         S_MV_MR: begin
            state_in = S_MV_EX;
         end
         S_MV_EX: begin
            ex_in    = 17'(signed'(match_rd_ff[15:0])) - 17'(px_ff);
            ey_in    = 17'(signed'(match_rd_ff[31:16])) - 17'(py_ff);
            state_in = S_MV_SQX;
         end
         S_MV_SQX: begin
            sq_in    = ex_ff;
            sqa_in   = sq_prod;
            state_in = S_MV_SQY;
         end
         S_MV_SQY: begin
            sq_in    = ey_ff;
            sqb_in   = sq_prod;
            state_in = S_MV_CMP;
         end
         S_MV_CMP: begin
            best_in = dist_min;
            k_in    = MCW'(k_ff + 1'b1);
            if (k_in < mc_ff) begin
               m_addr   = MAW'(k_in);
               state_in = S_MV_EX;
            end else begin
               su_cmd.start = 1'b1;
               su_cmd.op    = SU_SQRT;
               su_cmd.a     = SU_W'(dist_min);
               state_in     = S_MV_SQRT;
            end
         end
         S_MV_SQRT: begin
            if (su_res.done) begin
               su_cmd.start = 1'b1;
               su_cmd.op    = SU_DIV;
               su_cmd.a     = WEIGHT_NUM;
               su_cmd.b     = (su_res.q == '0) ? SU_W'(1) : su_res.q;
               state_in     = S_MV_DIV;
            end
         end
         S_MV_DIV: begin
            if (su_res.done) begin
               w_in     = su_res.q[31:0];
               state_in = S_MV_ACC;
            end
         end
         S_MV_ACC: begin
            if (mv_ff == '0) begin
               cw_we    = 1'b1;
               mv_in    = dc_next - dc_ff;
               state_in = S_IDLE;
            end else begin
               cw_addr  = PIDX'(mv_ff - CW'(1));
               state_in = S_MV_CWADD;
            end
         end
         S_MV_CWADD: begin
            cw_we    = 1'b1;
            cw_wd    = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
            mv_in    = mv_ff + CW'(1);
            state_in = S_IDLE;
         end
         S_DR_TOT: begin
            if (mv_ff == '0) begin
               sel_in   = '0;
               state_in = S_DR_RD;
            end else begin
               cw_addr  = PIDX'(mv_ff - CW'(1));
               state_in = S_DR_MS;
            end
         end
         S_DR_MS: begin
            su_cmd.start = 1'b1;
            su_cmd.op    = SU_MUL;
            su_cmd.a     = SU_W'(cw_rd_ff);
            su_cmd.b     = SU_W'(req_ff.draw_fraction);
            state_in     = S_DR_MUL;
         end
         S_DR_MUL: begin
            if (su_res.done) begin
               target_in = su_res.q[47:16];
               lo_in     = '0;
               hi_in     = PIDX'(mv_ff - CW'(1));
               state_in  = S_DR_BS;
            end
         end
         S_DR_BS: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[PIDX:1];
               cw_addr  = mid_sum[PIDX:1];
               state_in = S_DR_BSC;
            end else begin
               sel_in   = lo_ff;
               state_in = S_DR_RD;
            end
         end
         S_DR_BSC: begin
            if (cw_rd_ff >= target_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + PIDX'(1);
            end
            state_in = S_DR_BS;
         end
         S_DR_RD: begin
            bank_addr = {bsel_ff, sel_ff};
            state_in  = S_DR_CP;
         end
         S_DR_CP: begin
            bank_we   = 1'b1;
            bank_addr = {~bsel_ff, dc_ff[PIDX-1:0]};
            bank_wd   = bank_rd_ff;
            px_in     = signed'(bank_rd_ff[15:0]);
            py_in     = signed'(bank_rd_ff[31:16]);
            sum_x_in  = sum_x_ff + SW'(px_in);
            sum_y_in  = sum_y_ff + SW'(py_in);
            state_in  = S_DR_SQX;
         end
         S_DR_SQX: begin
            sq_in    = 17'(px_ff);
            sqs_x_in = sqs_x_ff + QW'(sq_prod);
            state_in = S_DR_SQY;
         end
         S_DR_SQY: begin
            sq_in    = 17'(py_ff);
            sqs_y_in = sqs_y_ff + QW'(sq_prod);
            dc_in    = dc_next;
            axis_in  = 1'b0;
            state_in = (dc_next >= n_cur) ? S_F_MS : S_IDLE;
         end
         S_F_MS: begin
            su_cmd.start = 1'b1;
            su_cmd.op    = SU_DIV;
            su_cmd.a     = SU_W'(s_abs);
            su_cmd.b     = SU_W'(dc_ff);
            state_in     = S_F_MEAN;
         end
         S_F_MEAN: begin
            if (su_res.done) begin
               if (axis_ff) mean_y_in = mean_v;
               else mean_x_in = mean_v;
               su_cmd.start = 1'b1;
               su_cmd.op    = SU_MUL;
               su_cmd.a     = SU_W'(sq_sel);
               su_cmd.b     = SU_W'(dc_ff);
               state_in     = S_F_NSQ;
            end
         end
         S_F_NSQ: begin
            if (su_res.done) begin
               t1_in        = su_res.q;
               su_cmd.start = 1'b1;
               su_cmd.op    = SU_MUL;
               su_cmd.a     = SU_W'(s_abs);
               su_cmd.b     = SU_W'(s_abs);
               state_in     = S_F_SS;
            end
         end
         S_F_SS: begin
            if (su_res.done) begin
               su_cmd.start = 1'b1;
               su_cmd.op    = SU_SQRT;
               su_cmd.a     = (t1_ff >= su_res.q) ? t1_ff - su_res.q : '0;
               state_in     = S_F_SQRT;
            end
         end
         S_F_SQRT: begin
            if (su_res.done) begin
               su_cmd.start = 1'b1;
               su_cmd.op    = SU_DIV;
               su_cmd.a     = su_res.q;
               su_cmd.b     = SU_W'(dc_ff);
               state_in     = S_F_SD;
            end
         end
         S_F_SD: begin
            if (su_res.done) begin
               if (axis_ff) begin
                  sd_y_in  = su_res.q[29:0];
                  state_in = S_F_OUT;
               end else begin
                  sd_x_in  = su_res.q[29:0];
                  axis_in  = 1'b1;
                  state_in = S_F_MS;
               end
            end
         end
         S_F_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.mean_x = mean_x_ff;
               rsp_data_in.mean_y = mean_y_ff;
               rsp_data_in.spread = spread_v;
               rsp_data_in.status = status_v;
               bsel_in  = ~bsel_ff;
               mc_in    = '0;
               mv_in    = '0;
               dc_in    = '0;
               sum_x_in = '0;
               sum_y_in = '0;
               sqs_x_in = '0;
               sqs_y_in = '0;
               axis_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pu_ff        <= 9'd256;
         ms_ff        <= 16'd160;
         bsel_ff      <= 1'b0;
         mc_ff        <= '0;
         mv_ff        <= '0;
         dc_ff        <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sqs_x_ff     <= '0;
         sqs_y_ff     <= '0;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pu_ff        <= pu_in;
         ms_ff        <= ms_in;
         bsel_ff      <= bsel_in;
         mc_ff        <= mc_in;
         mv_ff        <= mv_in;
         dc_ff        <= dc_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sqs_x_ff     <= sqs_x_in;
         sqs_y_ff     <= sqs_y_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      k_ff        <= k_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      sqa_ff      <= sqa_in;
      sqb_ff      <= sqb_in;
      best_ff     <= best_in;
      w_ff        <= w_in;
      target_ff   <= target_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      sel_ff      <= sel_in;
      t1_ff       <= t1_in;
      mean_x_ff   <= mean_x_in;
      mean_y_ff   <= mean_y_in;
      sd_x_ff     <= sd_x_in;
      sd_y_ff     <= sd_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (bank_we) bank_ff[bank_addr] <= bank_wd;
      bank_rd_ff <= bank_ff[bank_addr];
   end

   always_ff @(posedge clock) begin
      if (cw_we) cw_ff[cw_addr] <= cw_wd;
      cw_rd_ff <= cw_ff[cw_addr];
   end

   always_ff @(posedge clock) begin
      if (m_we) match_ff[m_addr] <= m_wd;
      match_rd_ff <= match_ff[m_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_move_bound: assert property (@(posedge clock) disable iff (reset)
      32'(mv_ff) <= PARTICLE_SLOTS)
      else $error("move counter past particle slots");
   a_match_bound: assert property (@(posedge clock) disable iff (reset)
      32'(mc_ff) <= MATCH_SLOTS)
      else $error("match count past match slots");
   a_unit_free: assert property (@(posedge clock) disable iff (reset)
      su_cmd.start |-> !su_res.busy)
      else $error("serial unit started while busy");
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_F_OUT && (!rsp_valid_ff || rsp_ready))
      |=> (dc_ff == '0 && mv_ff == '0 && mc_ff == '0 && rsp_valid_ff))
      else $error("frame end did not clear counters or raise result");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/pfr_serial_unit.sv @@
// Bit-serial multiply, divide and square root unit shared by the sequencer.
`default_nettype none
module pfr_serial_unit
   import pfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire su_cmd_type cmd,
   output su_res_type      res
);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [1:0]      op_ff, op_in;
   logic [SU_W-1:0] x_ff, x_in;
   logic [SU_W-1:0] y_ff, y_in;
   logic [SU_W-1:0] z_ff, z_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic [SU_W:0]   rem_sh;
   logic [SU_W-1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      rem_sh  = {y_ff, x_ff[SU_W-1]};
      trial   = y_ff + z_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         case (cmd.op)
            SU_MUL: begin
               x_in = '0;
               y_in = cmd.a;
               z_in = cmd.b;
            end
            SU_DIV: begin
               x_in = cmd.a;
               y_in = '0;
               z_in = cmd.b;
            end
            default: begin
               x_in = cmd.a;
               y_in = '0;
               z_in = {2'b01, {(SU_W-2){1'b0}}};
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            SU_MUL: begin
               if (z_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  if (z_ff[0]) x_in = x_ff + y_ff;
                  y_in = {y_ff[SU_W-2:0], 1'b0};
                  z_in = {1'b0, z_ff[SU_W-1:1]};
               end
            end
            SU_DIV: begin
               if (rem_sh >= {1'b0, z_ff}) begin
                  y_in = SU_W'(rem_sh - {1'b0, z_ff});
                  x_in = {x_ff[SU_W-2:0], 1'b1};
               end else begin
                  y_in = rem_sh[SU_W-1:0];
                  x_in = {x_ff[SU_W-2:0], 1'b0};
               end
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == 7'(SU_W - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: begin
               if (x_ff >= trial) begin
                  x_in = x_ff - trial;
                  y_in = {1'b0, y_ff[SU_W-1:1]} + z_ff;
               end else begin
                  y_in = {1'b0, y_ff[SU_W-1:1]};
               end
               z_in   = {2'b00, z_ff[SU_W-1:2]};
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == 7'(SU_W / 2 - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
   end

   assign res.busy = busy_ff;
   assign res.done = done_ff;
   assign res.q    = (op_ff == SU_SQRT) ? y_ff : x_ff;
   assign res.r    = y_ff;

endmodule
`default_nettype wire
